FILE: design/rfptf_pkg.sv
`timescale 1ns / 1ps
// rfptf_pkg: shared types and constants of the rf pulse train framer
// no dependencies

package rfptf_pkg;

  localparam int TIME_W    = 32;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int EV_W      = 5;

  // event kind codes as they leave on out_tuser
  localparam logic [KIND_W-1:0] KIND_SYNC    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DATA    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LEN_ERR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LVL_ERR = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_LOW   = 2'd3;

  localparam logic [TIME_W-1:0] MIN_PULSE_RST = 32'd450;
  localparam logic [TIME_W-1:0] SYNC_LOW_RST  = 32'd8000;
  localparam logic [TIME_W-1:0] SYNC_HIGH_RST = 32'd10000;
  localparam logic [TIME_W-1:0] END_LOW_RST   = 32'd10000;

  // events one edge can raise, listed in reverse of the order they go out
  typedef struct packed {
    logic lvl_err;
    logic end_ev;
    logic data;
    logic sync;
    logic len_err;
  } ev_flags_t;

  // work item handed from the classifier to the emitter
  typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic [TIME_W-1:0] pulse_us;
    logic              level;
    ev_flags_t         ev;
  } plan_t;

endpackage

FILE: design/rfptf_front.sv
`timescale 1ns / 1ps
// rfptf_front: edge classifier, holds configuration and framing state
// depends on rfptf_pkg

module rfptf_front
  import rfptf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_wdata,
  input  logic                 accept,
  input  logic [TIME_W-1:0]    time_us,
  input  logic                 line_level,
  output logic                 push,
  output plan_t                plan
);

  logic [TIME_W-1:0] min_pulse_r, sync_low_r, sync_high_r, end_low_r;
  logic              edge_seen_r, recording_r, lvl_valid_r, lvl_r;
  logic [TIME_W-1:0] last_time_r;

  logic [TIME_W-1:0] len;
  logic              is_short, is_sync, is_end, rec_eff, lvl_err;
  ev_flags_t         ev;

  always_comb begin
    len      = time_us - last_time_r;
    is_short = len < min_pulse_r;
    is_sync  = !is_short && (len < sync_high_r) && (len > sync_low_r);
    is_end   = len > end_low_r;
    rec_eff  = !is_short && (recording_r || is_sync);
    // a sync forgets the previous level, so no level error with it
    lvl_err  = rec_eff && !is_sync && lvl_valid_r && (line_level == lvl_r);

    ev.len_err = edge_seen_r && is_short && recording_r;
    ev.sync    = edge_seen_r && is_sync;
    ev.data    = edge_seen_r && rec_eff;
    ev.end_ev  = edge_seen_r && rec_eff && is_end;
    ev.lvl_err = edge_seen_r && lvl_err;
  end

  assign push          = accept && (ev != '0);
  assign plan.time_us  = time_us;
  assign plan.pulse_us = len;
  assign plan.level    = line_level;
  assign plan.ev       = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r <= MIN_PULSE_RST;
      sync_low_r  <= SYNC_LOW_RST;
      sync_high_r <= SYNC_HIGH_RST;
      end_low_r   <= END_LOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_PULSE: min_pulse_r <= cfg_wdata;
        REG_SYNC_LOW:  sync_low_r  <= cfg_wdata;
        REG_SYNC_HIGH: sync_high_r <= cfg_wdata;
        REG_END_LOW:   end_low_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_seen_r <= 1'b0;
      last_time_r <= '0;
      recording_r <= 1'b0;
      lvl_valid_r <= 1'b0;
      lvl_r       <= 1'b0;
    end else if (accept) begin
      edge_seen_r <= 1'b1;
      last_time_r <= time_us;
      if (edge_seen_r) begin
        if (is_short) begin
          recording_r <= 1'b0;
        end else if (rec_eff) begin
          recording_r <= !(is_end || lvl_err);
          lvl_valid_r <= 1'b1;
          lvl_r       <= line_level;
        end
      end
    end
  end

endmodule

FILE: design/rfptf_queue.sv
`timescale 1ns / 1ps
// rfptf_queue: small fifo of work items between classifier and emitter
// depends on rfptf_pkg

module rfptf_queue
  import rfptf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  plan_t wr_data,
  input  logic  pop,
  output plan_t rd_data,
  output logic  not_empty,
  output logic  not_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  plan_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign not_empty = count_r != '0;
  assign not_full  = count_r != FULL_CNT;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/rfptf_back.sv
`timescale 1ns / 1ps
// rfptf_back: walks the events of the queue head, one output beat per cycle while out_tready holds
// depends on rfptf_pkg

module rfptf_back
  import rfptf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  plan_t             head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [KIND_W-1:0] out_kind,
  output logic              out_level,
  output logic [TIME_W-1:0] out_pulse_us,
  output logic [TIME_W-1:0] out_time_us,
  output logic              out_last
);

  ev_flags_t         done_r, pending, sel, rest;
  logic              load;
  logic [KIND_W-1:0] kind_nxt;
  logic              valid_r, level_r, last_r;
  logic [KIND_W-1:0] kind_r;
  logic [TIME_W-1:0] pulse_r, time_r;

  always_comb begin
    pending  = head.ev & ~done_r;
    sel      = '0;
    kind_nxt = KIND_SYNC;
    priority if (pending.len_err) begin
      sel.len_err = 1'b1;
      kind_nxt    = KIND_LEN_ERR;
    end else if (pending.sync) begin
      sel.sync = 1'b1;
      kind_nxt = KIND_SYNC;
    end else if (pending.data) begin
      sel.data = 1'b1;
      kind_nxt = KIND_DATA;
    end else if (pending.end_ev) begin
      sel.end_ev = 1'b1;
      kind_nxt   = KIND_END;
    end else if (pending.lvl_err) begin
      sel.lvl_err = 1'b1;
      kind_nxt    = KIND_LVL_ERR;
    end else begin
      sel      = '0;
      kind_nxt = KIND_SYNC;
    end
    rest = pending & ~sel;
  end

  assign load = head_valid && (!valid_r || out_tready);
  assign pop  = load && (rest == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        done_r  <= (rest == '0) ? '0 : (done_r | sel);
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind_nxt;
      level_r <= sel.data & head.level;
      pulse_r <= sel.data ? head.pulse_us : '0;
      time_r  <= head.time_us;
      last_r  <= rest == '0;
    end
  end

  assign out_tvalid   = valid_r;
  assign out_kind     = kind_r;
  assign out_level    = level_r;
  assign out_pulse_us = pulse_r;
  assign out_time_us  = time_r;
  assign out_last     = last_r;

endmodule

FILE: design/rf_pulse_train_framer_core.sv
`timescale 1ns / 1ps
// rf_pulse_train_framer_core: top level of the rf pulse train framer
// depends on rfptf_pkg, rfptf_front, rfptf_queue, rfptf_back

// Frames pulse trains from an rf receiver. Each input beat is one line edge
// (microsecond timestamp, level after the edge). The edge is classified in
// the cycle it is accepted and its events (sync, data pulse, end, length
// error, level error; up to three per edge) are queued as one work item. The
// emitter then sends one event beat per cycle while out_tready holds, tlast
// on the final event of the edge. An edge is accepted every cycle while the
// queue has room; a sustained stream is limited by the events per edge, set
// by the single output register. Edges that raise no event (the very first
// edge, ignored short pulses, pulses outside a frame) never enter the queue.
// The first event beat of an edge passes through the queue and then the
// output register. The user must write thresholds through the cfg port only
// while the block is idle; the block itself does not enforce this.

module rf_pulse_train_framer_core
  import rfptf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_wdata,
  // edge input
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // [31:0] time_us, [32] line_level, rest zero
  // event output
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [71:0]          out_tdata,  // [0] pulse_level, [32:1] pulse_us,
                                           // [64:33] event_time_us, rest zero
  output logic [KIND_W-1:0]    out_tuser,  // [2:0] event_kind
  output logic                 out_tlast   // last_of_edge
);

  logic              accept, push, pop, q_not_empty, q_not_full;
  plan_t             plan, head;
  logic              o_level;
  logic [TIME_W-1:0] o_pulse, o_time;

  // beat accepted whenever the queue can take a work item
  assign in_tready = q_not_full;
  assign accept    = in_tvalid && in_tready;

  rfptf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .time_us    (in_tdata[31:0]),
    .line_level (in_tdata[32]),
    .push       (push),
    .plan       (plan)
  );

  rfptf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (plan),
    .pop       (pop),
    .rd_data   (head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  rfptf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (q_not_empty),
    .head         (head),
    .pop          (pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_kind     (out_tuser),
    .out_level    (o_level),
    .out_pulse_us (o_pulse),
    .out_time_us  (o_time),
    .out_last     (out_tlast)
  );

  // pack the event fields, lowest field first, zero fill to whole bytes
  assign out_tdata = {7'd0, o_time, o_pulse, o_level};

endmodule

FILE: design/rfptf_checker.sv
`timescale 1ns / 1ps
// rfptf_checker: port level checks of the rf pulse train framer
// depends on rfptf_pkg, bound to rf_pulse_train_framer_core

module rfptf_checker
  import rfptf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [71:0]       out_tdata,
  input logic [KIND_W-1:0] out_tuser,
  input logic              out_tlast
);

  // non data events carry no level and no length
  a_non_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_DATA) |-> (out_tdata[32:0] == '0))
    else $error("non data event with level or length");

  // a sync is always followed by its data pulse from the same edge
  a_sync_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_SYNC) |-> !out_tlast)
    else $error("sync event marked last");

  // a length error is the only event of its edge
  a_len_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_LEN_ERR) |-> out_tlast)
    else $error("length error not last");

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled output beat changed");

endmodule

bind rf_pulse_train_framer_core rfptf_checker u_rfptf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
